@@ rtl/tw_spi_pkg.sv @@
// shared types and constants for the three-wire spi register master
package tw_spi_pkg;

  localparam int HDR_BITS    = 9;
  localparam int DAT_BITS    = 16;
  localparam int READ_BIT    = 7;
  localparam int PRE_CLOCKS  = 2;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // transaction phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_HDR   = 3'd2,
    PH_TURN  = 3'd3,
    PH_DATA  = 3'd4,
    PH_LAST  = 3'd5,
    PH_TRAIL = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  typedef logic [HDR_BITS-1:0] hdr_t;
  typedef logic [DAT_BITS-1:0] dat_t;
  typedef logic [CNT_W-1:0]    cnt_t;

endpackage

@@ rtl/three_wire_spi_register_master.sv @@
// three-wire spi register master, one half-clock tick per request
//
// Each request on the in_ channel is one half period of the serial clock.
// in_tdata carries the start flag, the 9-bit header, the 16-bit write value
// and the sampled level of the shared data pin. Every request produces
// exactly one result on the out_ channel: the pin levels for that tick
// (serial clock, data latch, data drive enable, active-low chip enable),
// busy and done flags, and on the done tick the header and data bits that
// were shifted back in.
// A transaction runs two enable-high clocks, the header MSB first, one
// turnaround clock on reads (bit 7 of the header), sixteen data bits, one
// sample tick and one trailing clock, then a done tick.
// The result is registered, shown in the cycle after its request is taken; a
// single logic pass updates the state, so one request per cycle unless stalled.
// The result register frees the input side: a request is taken whenever the
// result register is empty or its contents are being taken in that cycle.
// When the receiver stalls, the result holds and in_tready drops, so the
// serial state simply pauses.
// Reset (rst_n low, synchronous) returns to idle with enable high, drive
// on, clock low and the data latch low; no result is pending after reset.
module three_wire_spi_register_master (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_req[0], header_word[9:1], write_value[25:10], line_in[26], zero pad
  input  logic [tw_spi_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // clock_pin[0], data_out_pin[1], data_drive[2], enable_pin[3], busy_res[4],
  // done_res[5], header_echo[14:6], read_value[30:15], zero pad
  output logic [tw_spi_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tw_spi_pkg::*;

  // input field split
  logic start_req;
  hdr_t header_word;
  dat_t write_value;
  logic line_in;

  assign start_req   = in_tdata[0];
  assign header_word = in_tdata[HDR_BITS:1];
  assign write_value = in_tdata[HDR_BITS+DAT_BITS:HDR_BITS+1];
  assign line_in     = in_tdata[HDR_BITS+DAT_BITS+1];

  // transfer state
  phase_t phase_r, phase_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   half_r, half_nxt;
  hdr_t   hsh_r, hsh_nxt;
  dat_t   dsh_r, dsh_nxt;
  logic   rd_r, rd_nxt;
  logic   pin_en_r, pin_en_nxt;
  logic   pin_drv_r, pin_drv_nxt;
  logic   pin_clk_r, pin_clk_nxt;
  logic   pin_dat_r, pin_dat_nxt;

  // result of this tick
  logic busy_c, done_c;
  hdr_t echo_c;
  dat_t rv_c;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   in_acc;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // next transfer state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    half_nxt    = half_r;
    hsh_nxt     = hsh_r;
    dsh_nxt     = dsh_r;
    rd_nxt      = rd_r;
    pin_en_nxt  = pin_en_r;
    pin_drv_nxt = pin_drv_r;
    pin_clk_nxt = pin_clk_r;
    pin_dat_nxt = pin_dat_r;
    busy_c      = 1'b1;
    done_c      = 1'b0;
    echo_c      = '0;
    rv_c        = '0;

    // start latches the frame and falls into the first preamble tick
    if (phase_r == PH_IDLE && start_req) begin
      hsh_nxt   = header_word;
      dsh_nxt   = write_value;
      rd_nxt    = header_word[READ_BIT];
      phase_nxt = PH_PRE;
      cnt_nxt   = '0;
      half_nxt  = 1'b0;
    end

    unique case (phase_nxt)
      PH_PRE: begin
        pin_en_nxt  = 1'b1;
        pin_drv_nxt = 1'b1;
        if (!half_nxt) begin
          pin_clk_nxt = 1'b0;
          half_nxt    = 1'b1;
        end else begin
          pin_clk_nxt = 1'b1;
          half_nxt    = 1'b0;
          cnt_nxt     = cnt_nxt + cnt_t'(1);
          if (cnt_nxt == CNT_W'(PRE_CLOCKS)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_HDR;
          end
        end
      end
      PH_HDR: begin
        pin_en_nxt  = 1'b0;
        pin_drv_nxt = 1'b1;
        if (!half_nxt) begin
          if (cnt_nxt != '0) hsh_nxt = {hsh_nxt[HDR_BITS-2:0], line_in};
          pin_dat_nxt = hsh_nxt[HDR_BITS-1];
          pin_clk_nxt = 1'b0;
          half_nxt    = 1'b1;
        end else begin
          pin_clk_nxt = 1'b1;
          half_nxt    = 1'b0;
          cnt_nxt     = cnt_nxt + cnt_t'(1);
          if (cnt_nxt == CNT_W'(HDR_BITS)) begin
            cnt_nxt   = '0;
            phase_nxt = rd_nxt ? PH_TURN : PH_DATA;
          end
        end
      end
      PH_TURN: begin
        pin_en_nxt  = 1'b0;
        pin_drv_nxt = 1'b0;
        if (!half_nxt) begin
          hsh_nxt     = {hsh_nxt[HDR_BITS-2:0], line_in};
          pin_clk_nxt = 1'b0;
          half_nxt    = 1'b1;
        end else begin
          pin_clk_nxt = 1'b1;
          half_nxt    = 1'b0;
          cnt_nxt     = '0;
          phase_nxt   = PH_DATA;
        end
      end
      PH_DATA: begin
        pin_en_nxt  = 1'b0;
        pin_drv_nxt = !rd_nxt;
        if (!half_nxt) begin
          // first low tick still samples the last header bit on writes
          if (cnt_nxt == '0) begin
            if (!rd_nxt) hsh_nxt = {hsh_nxt[HDR_BITS-2:0], line_in};
          end else begin
            dsh_nxt = {dsh_nxt[DAT_BITS-2:0], line_in};
          end
          pin_dat_nxt = dsh_nxt[DAT_BITS-1];
          pin_clk_nxt = 1'b0;
          half_nxt    = 1'b1;
        end else begin
          pin_clk_nxt = 1'b1;
          half_nxt    = 1'b0;
          cnt_nxt     = cnt_nxt + cnt_t'(1);
          if (cnt_nxt == CNT_W'(DAT_BITS)) begin
            cnt_nxt   = '0;
            phase_nxt = PH_LAST;
          end
        end
      end
      PH_LAST: begin
        dsh_nxt     = {dsh_nxt[DAT_BITS-2:0], line_in};
        pin_en_nxt  = 1'b0;
        pin_clk_nxt = 1'b0;
        half_nxt    = 1'b0;
        phase_nxt   = PH_TRAIL;
      end
      PH_TRAIL: begin
        pin_en_nxt  = 1'b1;
        pin_drv_nxt = 1'b1;
        if (!half_nxt) begin
          pin_clk_nxt = 1'b0;
          half_nxt    = 1'b1;
        end else begin
          pin_clk_nxt = 1'b1;
          half_nxt    = 1'b0;
          phase_nxt   = PH_DONE;
        end
      end
      PH_DONE: begin
        pin_en_nxt  = 1'b1;
        pin_drv_nxt = 1'b1;
        pin_clk_nxt = 1'b0;
        busy_c      = 1'b0;
        done_c      = 1'b1;
        echo_c      = hsh_nxt;
        rv_c        = dsh_nxt;
        phase_nxt   = PH_IDLE;
        cnt_nxt     = '0;
        half_nxt    = 1'b0;
      end
      default: begin
        busy_c      = 1'b0;
        pin_clk_nxt = 1'b0;
        pin_en_nxt  = 1'b1;
        pin_drv_nxt = 1'b1;
      end
    endcase
  end

  // state registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      half_r    <= 1'b0;
      hsh_r     <= '0;
      dsh_r     <= '0;
      rd_r      <= 1'b0;
      pin_en_r  <= 1'b1;
      pin_drv_r <= 1'b1;
      pin_clk_r <= 1'b0;
      pin_dat_r <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      half_r    <= half_nxt;
      hsh_r     <= hsh_nxt;
      dsh_r     <= dsh_nxt;
      rd_r      <= rd_nxt;
      pin_en_r  <= pin_en_nxt;
      pin_drv_r <= pin_drv_nxt;
      pin_clk_r <= pin_clk_nxt;
      pin_dat_r <= pin_dat_nxt;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUT_TDATA_W'({rv_c, echo_c, done_c, busy_c, pin_en_nxt,
                                  pin_drv_nxt, pin_dat_nxt, pin_clk_nxt});
    end
  end

  // done tick shows idle pins and is not busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[5] |-> !out_data_r[4] && out_data_r[3] &&
      out_data_r[2] && !out_data_r[0])
    else $error("done result without idle pin levels");

  // a tick taken in the done phase returns the block to idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_DONE |=> phase_r == PH_IDLE && out_data_r[5])
    else $error("done phase did not end the transfer");

  // chip enable stays low from the turnaround or data phase until the sample tick
  a_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TURN || phase_r == PH_DATA || phase_r == PH_LAST |-> !pin_en_r)
    else $error("chip enable high during a transfer");

  // a stalled result keeps the transfer state frozen
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(phase_r) && $stable(cnt_r)
      && $stable(half_r))
    else $error("transfer state moved while the result was stalled");

endmodule
